### sv/ssio_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssio_pkg
// Shared types and constants for the soft-switch I/O page decoder.
// ----------------------------------------------------------------------------
package ssio_pkg;

  localparam int unsigned REGION_SIZE_DEF = 256;
  localparam logic [15:0] REGION_BASE_RST = 16'hC000;

  typedef enum logic [1:0] {
    OP_READ       = 2'd0,
    OP_WRITE      = 2'd1,
    OP_KEY_CODE   = 2'd2,
    OP_KEY_STROBE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  // Switch and status addresses (absolute, independent of region base)
  localparam logic [15:0] ADDR_KBD        = 16'hC000;
  localparam logic [15:0] ADDR_STORE80_ON = 16'hC001;
  localparam logic [15:0] ADDR_CXROM_ON   = 16'hC006;
  localparam logic [15:0] ADDR_CXROM_OFF  = 16'hC007;
  localparam logic [15:0] ADDR_C3ROM_OFF  = 16'hC00A;
  localparam logic [15:0] ADDR_C3ROM_ON   = 16'hC00B;
  localparam logic [15:0] ADDR_COL80_OFF  = 16'hC00C;
  localparam logic [15:0] ADDR_COL80_ON   = 16'hC00D;
  localparam logic [15:0] ADDR_ALTCH_OFF  = 16'hC00E;
  localparam logic [15:0] ADDR_ALTCH_ON   = 16'hC00F;
  localparam logic [15:0] ADDR_STROBE     = 16'hC010;
  localparam logic [15:0] ADDR_RD_CXROM   = 16'hC015;
  localparam logic [15:0] ADDR_RD_C3ROM   = 16'hC017;
  localparam logic [15:0] ADDR_RD_VBL     = 16'hC019;
  localparam logic [15:0] ADDR_RD_TEXT    = 16'hC01A;
  localparam logic [15:0] ADDR_RD_MIXED   = 16'hC01B;
  localparam logic [15:0] ADDR_RD_PAGE2   = 16'hC01C;
  localparam logic [15:0] ADDR_RD_HIRES   = 16'hC01D;
  localparam logic [15:0] ADDR_RD_ALTCH   = 16'hC01E;
  localparam logic [15:0] ADDR_RD_COL80   = 16'hC01F;
  localparam logic [15:0] ADDR_SPEAKER    = 16'hC030;
  localparam logic [15:0] ADDR_MODE_LO    = 16'hC050;
  localparam logic [15:0] ADDR_MODE_HI    = 16'hC057;

  // Mode switch select, address bits [2:1]
  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_MIXED = 2'd1;
  localparam logic [1:0] MODE_PAGE2 = 2'd2;
  localparam logic [1:0] MODE_HIRES = 2'd3;

endpackage

### sv/ssio_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssio_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssio_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/ssio_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssio_obuf
// Two-entry output buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module ssio_obuf (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_data,
  output logic [1:0] occupancy,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data
);

  logic       skid_valid;
  logic [7:0] skid_data;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign occupancy = {1'b0, out_valid} + {1'b0, skid_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        read_data <= skid_data;
      end else if (push) begin
        read_data <= push_data;
      end
      if (push) begin
        skid_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid && out_valid && !out_ready))
    else $error("push into full output buffer");

endmodule

### sv/soft_switch_io_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_switch_io_decoder_top
// Soft-switch I/O page decoder with mode flags and a RAM backing store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one bus access or keyboard
//   event per transfer: operation, address, value. Only a bus read makes
//   a result; it leaves on the output channel (out_valid/out_ready) as
//   read_data. Writes, key code and key strobe events make no result.
//   Config channel (cfg_valid/cfg_data) loads region_base; always ready,
//   write it only while the block is idle.
// Read path: a read transfer passes the backing-store RAM read (read
//   stage) and then the output buffer, whose output register drives
//   read_data.
// Throughput: one item per cycle while in_ready is high, set by the single
//   RAM write/read port pair and the one-entry read stage.
// Reset: flags and key state take their reset values at once; then the
//   backing store is cleared one entry per cycle, all REGION_SIZE entries,
//   with in_ready low. Config writes are taken during that pass.
// Stall: a two-entry output buffer absorbs results; in_ready drops only
//   when buffer plus read in flight would overflow it, or while clearing.
// ----------------------------------------------------------------------------
module soft_switch_io_decoder_top #(
  parameter int unsigned REGION_SIZE = ssio_pkg::REGION_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [7:0]  value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data
);

  import ssio_pkg::*;

  localparam int unsigned IDX_W = $clog2(REGION_SIZE);
  localparam logic [16:0] SIZE_17 = 17'(REGION_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_SIZE - 1);

  // Control state
  state_t            state;
  logic [IDX_W-1:0]  clr_idx;
  logic [15:0]       region_base;

  // Soft-switch flags and keyboard latch
  logic text_mode, mixed_mode, page_two, hires_mode;
  logic alt_charset, col80_mode, store80_mode, slot_cx_rom, slot_c3_rom;
  logic key_strobe;
  logic [7:0] key_code;

  logic text_mode_next, mixed_mode_next, page_two_next, hires_mode_next;
  logic alt_charset_next, col80_mode_next, store80_mode_next;
  logic slot_cx_rom_next, slot_c3_rom_next, key_strobe_next;
  logic [7:0] key_code_next;

  // Read stage (RAM read in flight)
  logic       s1_valid, s1_store, s1_in_range;
  logic [7:0] s1_imm;

  logic       in_fire, pop;
  op_t        op;
  logic [15:0] offset;
  logic       in_range, mode_hit;
  logic       rd_store, wr_store;
  logic [7:0] imm;
  logic       ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0] ram_wdata, ram_q;
  logic [1:0] occupancy;
  logic [2:0] fill;
  logic       push;
  logic [7:0] push_data;

  assign cfg_ready = 1'b1;
  assign op        = op_t'(operation);
  assign in_fire   = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Buffer level after this cycle's moves; room for one more read
  assign fill     = {1'b0, occupancy} + {2'b00, s1_valid} - {2'b00, pop};
  assign in_ready = (state == ST_RUN) && (fill <= 3'd1);

  assign offset   = address - region_base;
  assign in_range = {1'b0, offset} < SIZE_17;
  assign mode_hit = (address >= ADDR_MODE_LO) && (address <= ADDR_MODE_HI);

  always_comb begin
    text_mode_next    = text_mode;
    mixed_mode_next   = mixed_mode;
    page_two_next     = page_two;
    hires_mode_next   = hires_mode;
    alt_charset_next  = alt_charset;
    col80_mode_next   = col80_mode;
    store80_mode_next = store80_mode;
    slot_cx_rom_next  = slot_cx_rom;
    slot_c3_rom_next  = slot_c3_rom;
    key_strobe_next   = key_strobe;
    key_code_next     = key_code;
    rd_store          = 1'b0;
    wr_store          = 1'b0;
    imm               = '0;

    // C050-C057 act the same for reads and writes
    if (in_fire && mode_hit && (op == OP_READ || op == OP_WRITE)) begin
      imm = {7'b0, address[0]};
      unique case (address[2:1])
        MODE_TEXT:  text_mode_next  = address[0];
        MODE_MIXED: mixed_mode_next = address[0];
        MODE_PAGE2: page_two_next   = address[0];
        MODE_HIRES: hires_mode_next = address[0];
        default:    text_mode_next  = text_mode;
      endcase
    end

    if (in_fire && !mode_hit) begin
      unique case (op)
        OP_READ: begin
          unique case (address)
            ADDR_KBD:      imm = key_code | {key_strobe, 7'b0};
            ADDR_STROBE: begin
              imm             = {key_strobe, 7'b0};
              key_strobe_next = 1'b0;
            end
            ADDR_RD_CXROM: imm = {slot_cx_rom, 7'b0};
            ADDR_RD_C3ROM: imm = {slot_c3_rom, 7'b0};
            ADDR_RD_VBL:   imm = '0;
            ADDR_RD_TEXT:  imm = {text_mode, 7'b0};
            ADDR_RD_MIXED: imm = {mixed_mode, 7'b0};
            ADDR_RD_PAGE2: imm = {page_two, 7'b0};
            ADDR_RD_HIRES: imm = {hires_mode, 7'b0};
            ADDR_RD_ALTCH: imm = {alt_charset, 7'b0};
            ADDR_RD_COL80: imm = {col80_mode, 7'b0};
            ADDR_SPEAKER:  imm = '0;
            default:       rd_store = 1'b1;
          endcase
        end
        OP_WRITE: begin
          unique case (address)
            ADDR_KBD, ADDR_STORE80_ON:    store80_mode_next = address[0];
            ADDR_CXROM_ON:                slot_cx_rom_next  = 1'b1;
            ADDR_CXROM_OFF:               slot_cx_rom_next  = 1'b0;
            ADDR_C3ROM_OFF, ADDR_C3ROM_ON: slot_c3_rom_next = address[0];
            ADDR_COL80_OFF, ADDR_COL80_ON: col80_mode_next  = address[0];
            ADDR_ALTCH_OFF, ADDR_ALTCH_ON: alt_charset_next = address[0];
            ADDR_STROBE:                  key_strobe_next   = 1'b0;
            default:                      wr_store = in_range;
          endcase
        end
        OP_KEY_CODE:   key_code_next   = value;
        OP_KEY_STROBE: key_strobe_next = 1'b1;
        default:       key_code_next   = key_code;
      endcase
    end else if (in_fire) begin
      unique case (op)
        OP_KEY_CODE:   key_code_next   = value;
        OP_KEY_STROBE: key_strobe_next = 1'b1;
        default:       key_code_next   = key_code;
      endcase
    end
  end

  // Clearing pass owns the write port until done
  assign ram_we    = (state == ST_CLEAR) || wr_store;
  assign ram_waddr = (state == ST_CLEAR) ? clr_idx : offset[IDX_W-1:0];
  assign ram_wdata = (state == ST_CLEAR) ? 8'h00 : value;

  ssio_ram #(
    .WIDTH (8),
    .DEPTH (REGION_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_store),
    .raddr (offset[IDX_W-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      region_base  <= REGION_BASE_RST;
      text_mode    <= 1'b1;
      mixed_mode   <= 1'b0;
      page_two     <= 1'b0;
      hires_mode   <= 1'b0;
      alt_charset  <= 1'b0;
      col80_mode   <= 1'b0;
      store80_mode <= 1'b0;
      slot_cx_rom  <= 1'b0;
      slot_c3_rom  <= 1'b0;
      key_strobe   <= 1'b0;
      key_code     <= '0;
      s1_valid     <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= ST_RUN;
          end
        end
        ST_RUN:   state <= ST_RUN;
        default:  state <= ST_CLEAR;
      endcase
      if (cfg_valid && cfg_ready) begin
        region_base <= cfg_data;
      end
      text_mode    <= text_mode_next;
      mixed_mode   <= mixed_mode_next;
      page_two     <= page_two_next;
      hires_mode   <= hires_mode_next;
      alt_charset  <= alt_charset_next;
      col80_mode   <= col80_mode_next;
      store80_mode <= store80_mode_next;
      slot_cx_rom  <= slot_cx_rom_next;
      slot_c3_rom  <= slot_c3_rom_next;
      key_strobe   <= key_strobe_next;
      key_code     <= key_code_next;
      s1_valid     <= in_fire && (op == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    s1_store    <= rd_store;
    s1_in_range <= in_range;
    s1_imm      <= imm;
  end

  // Out-of-range store reads return zero
  assign push      = s1_valid;
  assign push_data = s1_store ? (s1_in_range ? ram_q : 8'h00) : s1_imm;

  ssio_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .occupancy (occupancy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data)
  );

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("input accepted during store clearing pass");

  a_read_tracked: assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == OP_READ) |=> s1_valid)
    else $error("accepted read not tracked in read stage");

endmodule
